FILE: src/rssi_window_averager_core_defines.svh
// Assertion helpers for the checker file.
`ifndef RSSI_WINDOW_AVERAGER_CORE_DEFINES_SVH
`define RSSI_WINDOW_AVERAGER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define RWA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define RWA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

FILE: src/rwa_pkg.sv
`timescale 1ns / 1ps

package rwa_pkg;

    localparam int RSSI_BITS    = 7;
    localparam int COUNT_BITS   = 16;
    localparam int TIME_BITS    = 32;
    localparam int SUM_BITS     = 24;
    localparam int WIN_BITS     = 16;
    localparam int DVD_BITS     = SUM_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

    localparam logic [WIN_BITS-1:0]   WINDOW_RESET = WIN_BITS'(1000);
    localparam logic [RSSI_BITS-1:0]  RSSI_MAX     = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX      = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        FUNC_SAMPLE     = 2'd0,
        FUNC_RESTART    = 2'd1,
        FUNC_INVALIDATE = 2'd2
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DVD_BITS-1:0]   dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

endpackage

FILE: src/rwa_div.sv
`timescale 1ns / 1ps

module rwa_div import rwa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [DVD_BITS-1:0] o_quotient
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0]   r_rem, n_rem;
    logic [COUNT_BITS-1:0]   r_dvs, n_dvs;
    logic [DVD_BITS-1:0]     r_quo, n_quo;

    logic [COUNT_BITS:0]     w_trial;
    logic [COUNT_BITS:0]     w_diff;
    logic                    w_ge;

    // The dividend shifts out of the top of r_quo while quotient bits enter at the bottom.
    assign w_trial = {r_rem, r_quo[DVD_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_BITS'(DVD_BITS);
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            n_quo = {r_quo[DVD_BITS-2:0], w_ge};
            n_cnt = r_cnt - DIV_CNT_BITS'(1);
            if (r_cnt == DIV_CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/rssi_window_averager_core.sv
`timescale 1ns / 1ps
// Timing: a word that does not close a window shows its result in the cycle after acceptance.
// A sample that closes a window starts the restoring divider, which makes one bit of the
// mean per cycle (25 steps); the core then takes the quotient and registers the result.
// Throughput: one word per cycle without a close unless the result stalls; none while the divider runs.
// Reset (synchronous, active low) clears control and sum state and sets the window to 1000 ms.

module rssi_window_averager_core import rwa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [WIN_BITS-1:0]  i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [RSSI_BITS-1:0] i_rssi_sample,
    input  logic [TIME_BITS-1:0] i_now_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [RSSI_BITS-1:0] o_shown_rssi,
    output logic                 o_average_valid,
    output logic                 o_window_closed
);

    t_state                r_state, n_state;
    logic [WIN_BITS-1:0]   r_window_ms;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic [TIME_BITS-1:0]  r_pend_now, n_pend_now;
    logic [RSSI_BITS-1:0]  r_avg, n_avg;
    logic                  r_avg_flag, n_avg_flag;
    logic [RSSI_BITS-1:0]  r_last_raw, n_last_raw;
    logic                  r_out_valid, n_out_valid;
    logic [RSSI_BITS-1:0]  r_out_shown, n_out_shown;
    logic                  r_out_avg_valid, n_out_avg_valid;
    logic                  r_out_closed, n_out_closed;

    t_func                 w_func;
    logic                  w_in_accept;
    logic [SUM_BITS:0]     w_sum_wide;
    logic [SUM_BITS-1:0]   w_sum_sat;
    logic [COUNT_BITS-1:0] w_count_inc;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic                  w_close;
    t_div_req              w_div_req;
    logic                  w_div_done;
    logic [DVD_BITS-1:0]   w_quotient;
    logic [RSSI_BITS-1:0]  w_mean;

    assign w_func      = t_func'(i_func);
    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_sum_wide  = (SUM_BITS + 1)'(r_sum) + (SUM_BITS + 1)'(i_rssi_sample);
    assign w_sum_sat   = w_sum_wide[SUM_BITS] ? SUM_MAX : w_sum_wide[SUM_BITS-1:0];
    assign w_count_inc = (r_count != COUNT_MAX) ? r_count + COUNT_BITS'(1) : r_count;
    assign w_elapsed   = i_now_ms - r_start;
    assign w_close     = (w_elapsed >= TIME_BITS'(r_window_ms)) && (w_count_inc != '0);

    // Rounded mean: the half count is added ahead of the division.
    assign w_div_req.start    = w_in_accept && (w_func == FUNC_SAMPLE) && w_close;
    assign w_div_req.dividend = DVD_BITS'(w_sum_sat) + DVD_BITS'(w_count_inc >> 1);
    assign w_div_req.divisor  = w_count_inc;

    rwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // A mean above the largest strength is possible only after the sample count saturated.
    assign w_mean = (|w_quotient[DVD_BITS-1:RSSI_BITS]) ? RSSI_MAX
                                                         : w_quotient[RSSI_BITS-1:0];

    always_comb begin
        n_state         = r_state;
        n_sum           = r_sum;
        n_count         = r_count;
        n_start         = r_start;
        n_pend_now      = r_pend_now;
        n_avg           = r_avg;
        n_avg_flag      = r_avg_flag;
        n_last_raw      = r_last_raw;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_shown     = r_out_shown;
        n_out_avg_valid = r_out_avg_valid;
        n_out_closed    = r_out_closed;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    unique case (w_func)
                        FUNC_SAMPLE: begin
                            n_last_raw = i_rssi_sample;
                            n_sum      = w_sum_sat;
                            n_count    = w_count_inc;
                            if (!r_avg_flag) begin
                                n_avg      = i_rssi_sample;
                                n_avg_flag = 1'b1;
                            end
                        end
                        FUNC_RESTART: begin
                            n_sum   = '0;
                            n_count = '0;
                            n_start = i_now_ms;
                        end
                        FUNC_INVALIDATE: begin
                            n_avg_flag = 1'b0;
                            n_sum      = '0;
                            n_count    = '0;
                            n_start    = i_now_ms;
                        end
                        default: begin
                        end
                    endcase

                    if (w_div_req.start) begin
                        n_pend_now = i_now_ms;
                        n_state    = ST_DIV;
                    end else begin
                        n_out_valid     = 1'b1;
                        n_out_shown     = n_avg_flag ? n_avg : n_last_raw;
                        n_out_avg_valid = n_avg_flag;
                        n_out_closed    = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_avg           = w_mean;
                    n_sum           = '0;
                    n_count         = '0;
                    n_start         = r_pend_now;
                    n_out_valid     = 1'b1;
                    n_out_shown     = w_mean;
                    n_out_avg_valid = r_avg_flag;
                    n_out_closed    = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window_ms <= WINDOW_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_start     <= '0;
            r_avg       <= '0;
            r_avg_flag  <= 1'b0;
            r_last_raw  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_window_ms <= i_cfg_wr_data;
            end
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_start     <= n_start;
            r_avg       <= n_avg;
            r_avg_flag  <= n_avg_flag;
            r_last_raw  <= n_last_raw;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_now      <= n_pend_now;
        r_out_shown     <= n_out_shown;
        r_out_avg_valid <= n_out_avg_valid;
        r_out_closed    <= n_out_closed;
    end

    assign o_out_valid     = r_out_valid;
    assign o_shown_rssi    = r_out_shown;
    assign o_average_valid = r_out_avg_valid;
    assign o_window_closed = r_out_closed;

endmodule

FILE: src/rwa_checker.sv
`timescale 1ns / 1ps
`include "rssi_window_averager_core_defines.svh"

module rwa_checker import rwa_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [1:0]           i_func,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [RSSI_BITS-1:0] o_shown_rssi,
    input logic                 o_average_valid,
    input logic                 o_window_closed
);

    // A stalled result word holds its contents.
    `RWA_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_shown_rssi) && $stable(o_average_valid) && $stable(o_window_closed)), "stalled result word changed")

    // Closing a window always leaves an established average.
    `RWA_ASSERT(a_close_valid, (o_out_valid && o_window_closed) |-> o_average_valid, "window closed without a valid average")

    // An invalidating restart answers on the next cycle with no average.
    `RWA_ASSERT(a_invalidate, (i_in_valid && !o_in_stall && i_func == FUNC_INVALIDATE) |=> (o_out_valid && !o_average_valid && !o_window_closed), "invalidate word gave a wrong result")

    // Reset empties the result register.
    `RWA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind rssi_window_averager_core rwa_checker u_rwa_checker (.*);
